// File: rtl/mpqa_pkg.sv
// ----------------------------------------------------------------------------
// mpqa_pkg: shared definitions for the min priority queue array
// Sizes, status codes, request kinds and the per-cell control struct.
// ----------------------------------------------------------------------------
package mpqa_pkg;

   // Queue capacity and derived widths
   localparam int DEPTH = 8;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int OCC_W = 4;
   localparam int ST_W  = 2;

   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [OCC_W-1:0]        occ_type;

   // Result status codes
   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Request kinds
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } cell_ctrl_type;

endpackage

// File: rtl/mpqa_if.sv
// ----------------------------------------------------------------------------
// mpqa_req_if / mpqa_rsp_if: request and result channels
// Valid/ready handshake with the payload fields of each channel.
// ----------------------------------------------------------------------------
interface mpqa_req_if;
   logic                valid;
   logic                ready;
   logic                req_type;
   mpqa_pkg::value_type value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mpqa_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   mpqa_pkg::value_type  removed_value;
   mpqa_pkg::occ_type    occupancy;

   modport source (output valid, output status, output removed_value,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input occupancy, output ready);
endinterface

// File: rtl/mpqa_cell.sv
// ----------------------------------------------------------------------------
// mpqa_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps its entry or takes the new value or
// its left neighbor's entry; on removal it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module mpqa_cell (
   input  logic                    clock,
   input  mpqa_pkg::cell_ctrl_type ctrl,
   input  mpqa_pkg::value_type     ins_value,
   input  logic                    occupied,
   input  logic                    prev_keep,
   input  mpqa_pkg::value_type     prev_entry,
   input  mpqa_pkg::value_type     next_entry,
   output logic                    keep,
   output mpqa_pkg::value_type     entry
);

   mpqa_pkg::value_type entry_ff;
   mpqa_pkg::value_type entry_in;

   // An occupied entry stays put when it is at or below the new value (ties keep order)
   assign keep  = occupied && !(ins_value < entry_ff);
   assign entry = entry_ff;

   // Next entry
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en && !keep) begin
         entry_in = prev_keep ? ins_value : prev_entry;
      end else if (ctrl.rem_en) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/min_priority_queue_array_unit.sv
// The result is registered and presented in the cycle after the request is accepted.
// Throughput: one request per cycle while results are drained; the cell chain updates in the accept cycle.
// A request is taken whenever the result register is empty or being drained.
// Reset (synchronous) clears the entry count and the result valid flag;
// stored entries are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// min_priority_queue_array_unit: ascending priority queue
// Entries live in a chain of cells kept sorted ascending, ties in insertion
// order, so the smallest (earliest among equals) always sits in cell zero.
// ----------------------------------------------------------------------------
module min_priority_queue_array_unit (
   input  logic     clock,
   input  logic     reset,
   mpqa_req_if.sink   req_if,
   mpqa_rsp_if.source rsp_if
);

   localparam int DEPTH = mpqa_pkg::DEPTH;
   localparam int CNT_W = mpqa_pkg::CNT_W;

   // Count and result registers
   mpqa_pkg::count_type  count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mpqa_pkg::status_type status_ff, status_in;
   mpqa_pkg::value_type  removed_ff, removed_in;
   mpqa_pkg::occ_type    occ_ff, occ_in;

   logic                    accept;
   logic                    is_remove;
   logic                    full;
   logic                    empty;
   mpqa_pkg::cell_ctrl_type ctrl;
   logic [31:0]             count_wide;

   logic                keep_w  [DEPTH];
   mpqa_pkg::value_type entry_w [DEPTH];

   // Handshake
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign is_remove    = (req_if.req_type == mpqa_pkg::REQ_REMOVE);
   assign full         = (count_ff == CNT_W'(DEPTH));
   assign empty        = (count_ff == '0);

   // Cell commands
   assign ctrl.ins_en = accept && !is_remove && !full;
   assign ctrl.rem_en = accept && is_remove && !empty;

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                occ;
      logic                p_keep;
      mpqa_pkg::value_type p_entry;
      mpqa_pkg::value_type n_entry;

      assign occ = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign p_keep  = 1'b1;
         assign p_entry = req_if.value;
      end else begin : g_body
         assign p_keep  = keep_w[i-1];
         assign p_entry = entry_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_entry = entry_w[i];
      end else begin : g_next
         assign n_entry = entry_w[i+1];
      end

      mpqa_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ins_value  (req_if.value),
         .occupied   (occ),
         .prev_keep  (p_keep),
         .prev_entry (p_entry),
         .next_entry (n_entry),
         .keep       (keep_w[i]),
         .entry      (entry_w[i])
      );
   end

   // Count and result next state
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rem_en) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         removed_in   = '0;
         status_in    = mpqa_pkg::ST_OK;
         if (is_remove) begin
            if (empty) begin
               status_in = mpqa_pkg::ST_EMPTY;
            end else begin
               removed_in = entry_w[0];
            end
         end else if (full) begin
            status_in = mpqa_pkg::ST_FULL;
         end
      end
   end

   // Occupancy is reported in the low bits of the count
   assign count_wide = 32'(count_in);
   assign occ_in     = accept ? count_wide[mpqa_pkg::OCC_W-1:0] : occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      removed_ff <= removed_in;
      occ_ff     <= occ_in;
   end

   // Result outputs
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.removed_value = removed_ff;
   assign rsp_if.occupancy     = occ_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the count");

   a_remove_head: assert property (@(posedge clock) disable iff (reset)
      ctrl.rem_en |=> rsp_valid_ff && removed_ff == $past(entry_w[0]))
      else $error("removal did not return the head entry");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      accept && !ctrl.ins_en && !ctrl.rem_en |=>
         removed_ff == '0 && $stable(count_ff))
      else $error("refused request changed state or returned a value");

endmodule

// File: verif/mpqa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqa_checker: result checker for the min priority queue array
// Watches both channels, keeps its own copy of the queue contents, works out
// the result owed for every accepted request and compares each delivered
// result with the oldest one still owed.
// ----------------------------------------------------------------------------
module mpqa_checker (
   input  logic clock,
   input  logic reset,
   mpqa_req_if  req_mon,
   mpqa_rsp_if  rsp_mon,
   output int   fail_count,
   output int   due_count
);

   // One result as the block should deliver it
   typedef struct {
      mpqa_pkg::status_type status;
      mpqa_pkg::value_type  removed;
      mpqa_pkg::occ_type    occupancy;
   } queue_result_type;

   // Held values in insertion order, and results not yet delivered
   mpqa_pkg::value_type held_vals[$];
   queue_result_type    due_results[$];

   // Apply one request to the held values and return its result
   function automatic queue_result_type queue_step(mpqa_pkg::req_kind_type kind,
                                                   mpqa_pkg::value_type val);
      queue_result_type res;
      int               pos;
      res.status  = mpqa_pkg::ST_OK;
      res.removed = '0;
      if (kind == mpqa_pkg::REQ_INSERT) begin
         if (held_vals.size() >= mpqa_pkg::DEPTH)
            res.status = mpqa_pkg::ST_FULL;
         else
            held_vals.push_back(val);
      end else if (held_vals.size() == 0) begin
         res.status = mpqa_pkg::ST_EMPTY;
      end else begin
         // strict less keeps the earliest of equal values
         pos = 0;
         for (int i = 1; i < held_vals.size(); i++)
            if (held_vals[i] < held_vals[pos])
               pos = i;
         res.removed = held_vals[pos];
         held_vals.delete(pos);
      end
      res.occupancy = mpqa_pkg::occ_type'(held_vals.size());
      return res;
   endfunction

   task automatic report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Requests and results are both sampled at the rising edge
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_vals.delete();
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               report("result with no request outstanding");
            end else begin
               want = due_results.pop_front();
               if (rsp_mon.status !== want.status)
                  report($sformatf("status %0d, want %0d", rsp_mon.status, want.status));
               if (rsp_mon.removed_value !== want.removed)
                  report($sformatf("removed_value %0d, want %0d",
                                   rsp_mon.removed_value, want.removed));
               if (rsp_mon.occupancy !== want.occupancy)
                  report($sformatf("occupancy %0d, want %0d",
                                   rsp_mon.occupancy, want.occupancy));
            end
         end
         if (req_mon.valid && req_mon.ready)
            due_results.push_back(
               queue_step(mpqa_pkg::req_kind_type'(req_mon.req_type), req_mon.value));
      end
      due_count <= due_results.size();
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for min_priority_queue_array_unit
// Drives directed and random insert/remove requests with random gaps on both
// channels, including two long result stalls and a full drain pause; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

   logic clock;
   logic reset;
   logic idle_on;
   int   errors;
   int   due_count;
   int   rsp_seen;

   mpqa_req_if req_ch ();
   mpqa_rsp_if rsp_ch ();

   min_priority_queue_array_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   mpqa_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (errors),
      .due_count  (due_count)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one request, after an optional gap, and hold it until taken
   task automatic send_req(mpqa_pkg::req_kind_type kind, mpqa_pkg::value_type val);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.value    <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering and wait until every owed result has come back
   task automatic drain_wait();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
   endtask

   // Mix of tiny values (ties), extremes and full-range values
   function automatic mpqa_pkg::value_type pick_value();
      int sel;
      sel = $urandom_range(0, 3);
      case (sel)
         0: return mpqa_pkg::value_type'($signed($urandom_range(0, 6)) - 3);
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sh0000_0000;
               default: return -32'sd1;
            endcase
         end
         default: return mpqa_pkg::value_type'($urandom);
      endcase
   endfunction

   // Result side: random stalls, plus two long hold-offs to back up the block
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      rsp_seen     = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_seen == 50 || rsp_seen == 1200) begin
            rsp_ch.ready <= 1'b0;
            repeat (64) @(posedge clock);
         end
         gap = idle_on ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         rsp_seen++;
      end
   end

   // Request side and verdict
   initial begin
      int                     ins_pct;
      mpqa_pkg::req_kind_type kind;
      reset           = 1'b1;
      idle_on         = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = mpqa_pkg::REQ_INSERT;
      req_ch.value    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: removal when empty, fill with extremes and ties,
      // insert when full, then empty it again past the bottom
      send_req(mpqa_pkg::REQ_REMOVE, 32'sh1234_5678);
      send_req(mpqa_pkg::REQ_INSERT, 32'sd5);
      send_req(mpqa_pkg::REQ_INSERT, 32'sh7fff_ffff);
      send_req(mpqa_pkg::REQ_INSERT, 32'sd5);
      send_req(mpqa_pkg::REQ_INSERT, 32'sh8000_0000);
      send_req(mpqa_pkg::REQ_INSERT, -32'sd1);
      send_req(mpqa_pkg::REQ_INSERT, 32'sd0);
      send_req(mpqa_pkg::REQ_INSERT, 32'sd5);
      send_req(mpqa_pkg::REQ_INSERT, 32'sd5);
      send_req(mpqa_pkg::REQ_INSERT, 32'sd7);
      repeat (mpqa_pkg::DEPTH + 1)
         send_req(mpqa_pkg::REQ_REMOVE, mpqa_pkg::value_type'($urandom));

      // Random: phases biased toward filling, draining or balance
      ins_pct = 50;
      for (int n = 0; n < 1830; n++) begin
         if (n % 150 == 0) begin
            case ((n / 150) % 5)
               0: ins_pct = 50;
               1: ins_pct = 75;
               2: ins_pct = 25;
               3: ins_pct = 90;
               default: ins_pct = 10;
            endcase
            idle_on <= ((n / 150) % 4 != 3);
         end
         if (n == 700)
            drain_wait();
         kind = ($urandom_range(0, 99) < ins_pct) ? mpqa_pkg::REQ_INSERT
                                                  : mpqa_pkg::REQ_REMOVE;
         send_req(kind, pick_value());
      end

      drain_wait();
      repeat (4) @(posedge clock);
      if (errors == 0 && due_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Run limit
   initial begin
      #400_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
rtl/mpqa_pkg.sv
rtl/mpqa_if.sv
rtl/mpqa_cell.sv
rtl/min_priority_queue_array_unit.sv
verif/mpqa_checker.sv
verif/tb_top.sv
